[rtl/tmrlm_pkg.sv]
// Shared types, codes and constants of the tile-masked radial light map unit.
package tmrlm_pkg;

    localparam int MAP_SIZE_DEF  = 384;
    localparam int TILE_SIZE_DEF = 32;

    localparam logic [7:0] ATTR_DAMP    = 8'd20;
    localparam logic [7:0] ATTR_OUTDOOR = 8'd22;

    localparam int SIDE_X_BIT   = 2;
    localparam int SIDE_Y_BIT   = 0;
    localparam int FLAG_OUT_BIT = 1;

    localparam int DIV_STEPS = 8;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTDOOR = 2'd1;

    localparam logic [2:0] FN_LOAD_TILE  = 3'd0;
    localparam logic [2:0] FN_FILL_BASE  = 3'd1;
    localparam logic [2:0] FN_LIGHT_BASE = 3'd2;
    localparam logic [2:0] FN_COPY       = 3'd3;
    localparam logic [2:0] FN_LIGHT_WORK = 3'd4;
    localparam logic [2:0] FN_READ_WORK  = 3'd5;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] side;
        logic [7:0] edge_x;
        logic [7:0] edge_y;
        logic [7:0] flags;
        logic [7:0] attr2;
    } tile_t;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         tile_index;
        tile_t              tile;
        logic signed [10:0] pos_x;
        logic signed [10:0] pos_y;
        logic [7:0]         radius;
        logic [7:0]         intensity;
    } req_t;

    typedef struct packed {
        logic capture;
        logic tile_wr;
        logic bounds;
        logic start_walk;
        logic reduce;
        logic row_start;
        logic square;
        logic eval;
        logic div_step;
        logic map_wr;
        logic advance;
        logic read_cap;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       box_empty;
        logic       reduce_done;
        logic       last_pixel;
        logic       in_circle;
        logic       out_free;
    } sts_t;

endpackage

[rtl/tmrlm_if.sv]
// Request, response and configuration channel interfaces.
interface tmrlm_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [7:0]         tile_index;
    logic [7:0]         tile_attr;
    logic [7:0]         tile_side_bits;
    logic [7:0]         tile_edge_x;
    logic [7:0]         tile_edge_y;
    logic [7:0]         tile_flags;
    logic [7:0]         tile_attr2;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [7:0]         radius;
    logic [7:0]         intensity;

    modport source (output valid, func, tile_index, tile_attr, tile_side_bits, tile_edge_x,
                    tile_edge_y, tile_flags, tile_attr2, pos_x, pos_y, radius, intensity,
                    input ready);
    modport sink (input valid, func, tile_index, tile_attr, tile_side_bits, tile_edge_x,
                  tile_edge_y, tile_flags, tile_attr2, pos_x, pos_y, radius, intensity,
                  output ready);
endinterface

interface tmrlm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] level;
    logic [2:0] func_echo;

    modport source (output valid, level, func_echo, input ready);
    modport sink (input valid, level, func_echo, output ready);
endinterface

interface tmrlm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tmrlm_pkg::CFG_IDX_W-1:0]   index;
    logic [7:0]                        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/tile_masked_radial_light_map_unit.sv]
// Top level of the tile-masked radial light map unit.
// One request is handled at a time; the request port is ready whenever the sequencer is idle,
// even while the previous result still waits in the response register. Fill and copy walk the
// whole map, reading and then writing each pixel through the write and read ports of each map
// RAM. A light first strips whole tiles off its clipped start corner (one tile per cycle), then
// squares and evaluates each box pixel, skips those outside the circle and runs those inside
// it through the bit-serial falloff divider before writing them. Map and tile memories
// are not cleared after reset; an entry must be written before it is read.
module tile_masked_radial_light_map_unit #(
    parameter int MAP_SIZE  = tmrlm_pkg::MAP_SIZE_DEF,
    parameter int TILE_SIZE = tmrlm_pkg::TILE_SIZE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    tmrlm_req_if.sink    req,
    tmrlm_rsp_if.source  rsp,
    tmrlm_cfg_if.sink    cfg
);

    tmrlm_pkg::cmd_t cmd;
    tmrlm_pkg::sts_t sts;
    tmrlm_pkg::req_t req_payload;
    logic            in_ready;

    assign req_payload.func        = req.func;
    assign req_payload.tile_index  = req.tile_index;
    assign req_payload.tile.attr   = req.tile_attr;
    assign req_payload.tile.side   = req.tile_side_bits;
    assign req_payload.tile.edge_x = req.tile_edge_x;
    assign req_payload.tile.edge_y = req.tile_edge_y;
    assign req_payload.tile.flags  = req.tile_flags;
    assign req_payload.tile.attr2  = req.tile_attr2;
    assign req_payload.pos_x       = req.pos_x;
    assign req_payload.pos_y       = req.pos_y;
    assign req_payload.radius      = req.radius;
    assign req_payload.intensity   = req.intensity;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    tmrlm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tmrlm_dp #(.MAP_SIZE(MAP_SIZE), .TILE_SIZE(TILE_SIZE)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req           (req_payload),
        .cfg_valid     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .rsp_level     (rsp.level),
        .rsp_func_echo (rsp.func_echo)
    );

endmodule

[rtl/tmrlm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tmrlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tmrlm_ctrl.sv]
// Operation sequencer: walks each request through its datapath steps.
module tmrlm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tmrlm_pkg::sts_t   sts,
    output tmrlm_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_REDUCE,
        ST_W_RD,
        ST_W_WR,
        ST_P_RD,
        ST_P_EV,
        ST_P_DIV,
        ST_P_WR,
        ST_R_RD,
        ST_R_CAP,
        ST_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.func)
                    tmrlm_pkg::FN_LOAD_TILE:
                    begin
                        cmd.tile_wr = 1'b1;
                        state_next  = ST_DONE;
                    end
                    tmrlm_pkg::FN_FILL_BASE, tmrlm_pkg::FN_COPY,
                    tmrlm_pkg::FN_LIGHT_BASE, tmrlm_pkg::FN_LIGHT_WORK:
                    begin
                        cmd.bounds = 1'b1;
                        state_next = ST_CHECK;
                    end
                    tmrlm_pkg::FN_READ_WORK:
                    begin
                        state_next = ST_R_RD;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CHECK:
            begin
                if (sts.box_empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.start_walk = 1'b1;
                    state_next     = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                // strip whole tiles off the start corner to find its tile
                if (sts.reduce_done)
                begin
                    cmd.row_start = 1'b1;
                    if (sts.func inside {tmrlm_pkg::FN_LIGHT_BASE, tmrlm_pkg::FN_LIGHT_WORK})
                    begin
                        state_next = ST_P_RD;
                    end
                    else
                    begin
                        state_next = ST_W_RD;
                    end
                end
                else
                begin
                    cmd.reduce = 1'b1;
                end
            end
            ST_W_RD:
            begin
                state_next = ST_W_WR;
            end
            ST_W_WR:
            begin
                cmd.map_wr  = 1'b1;
                cmd.advance = 1'b1;
                state_next  = sts.last_pixel ? ST_DONE : ST_W_RD;
            end
            ST_P_RD:
            begin
                cmd.square = 1'b1;
                state_next = ST_P_EV;
            end
            ST_P_EV:
            begin
                cmd.eval = 1'b1;
                cnt_next = '0;
                if (sts.in_circle)
                begin
                    state_next = ST_P_DIV;
                end
                else
                begin
                    // outside the circle: skip the pixel
                    cmd.advance = 1'b1;
                    state_next  = sts.last_pixel ? ST_DONE : ST_P_RD;
                end
            end
            ST_P_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg == 3'(tmrlm_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_P_WR;
                end
            end
            ST_P_WR:
            begin
                cmd.map_wr  = 1'b1;
                cmd.advance = 1'b1;
                state_next  = sts.last_pixel ? ST_DONE : ST_P_RD;
            end
            ST_R_RD:
            begin
                state_next = ST_R_CAP;
            end
            ST_R_CAP:
            begin
                cmd.read_cap = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the response register can take the result
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P_DIV && cnt_reg == 3'(tmrlm_pkg::DIV_STEPS - 1)) |=>
        (state_reg == ST_P_WR))
        else $error("divider did not hand over to write");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> in_ready)
        else $error("not ready after result load");

    a_capture_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_DECODE))
        else $error("captured request not decoded");

endmodule

[rtl/tmrlm_dp.sv]
// Datapath: request registers, pixel walker, mask logic, divider and map memories.
module tmrlm_dp #(
    parameter int MAP_SIZE  = tmrlm_pkg::MAP_SIZE_DEF,
    parameter int TILE_SIZE = tmrlm_pkg::TILE_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tmrlm_pkg::cmd_t                   cmd,
    output tmrlm_pkg::sts_t                   sts,
    input  tmrlm_pkg::req_t                   req,
    input  logic                              cfg_valid,
    input  logic [tmrlm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                        cfg_data,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic [7:0]                        rsp_level,
    output logic [2:0]                        rsp_func_echo
);

    localparam int TILES_SIDE = (MAP_SIZE + TILE_SIZE - 1) / TILE_SIZE;
    localparam int TILE_COUNT = TILES_SIDE * TILES_SIDE;
    localparam int PIXELS     = MAP_SIZE * MAP_SIZE;
    localparam int CW         = $clog2(MAP_SIZE);
    localparam int COL_W      = $clog2(TILES_SIDE + 1);
    localparam int TILE_AW    = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
    localparam int PIX_AW     = $clog2(PIXELS);

    // request registers
    logic [2:0]         func_reg;
    logic [7:0]         idx_reg;
    tmrlm_pkg::tile_t   tile_in_reg;
    logic signed [10:0] px_reg, py_reg;
    logic [7:0]         rad_reg, int_reg;
    logic [7:0]         ambient_reg, outdoor_reg;

    // walker
    logic signed [11:0] sx_reg, ex_reg, sy_reg, ey_reg;
    logic [CW-1:0]      x_reg, y_reg, offx_reg, offy_reg, sxo_reg;
    logic [COL_W-1:0]   col_reg, row_reg, sxc_reg;

    // pixel evaluation and divider
    logic [15:0] sqx_reg, sqy_reg;
    logic        lit_reg;
    logic [7:0]  shade_reg, pix_reg, q_reg, level_reg;
    logic [24:0] rem_reg;
    logic [22:0] dsh_reg;

    logic        out_valid_reg;
    logic [7:0]  out_level_reg;
    logic [2:0]  out_func_reg;

    logic [7:0]  amb, outl;
    assign amb  = ~ambient_reg;
    assign outl = ~outdoor_reg;

    logic is_light;
    assign is_light = (func_reg == tmrlm_pkg::FN_LIGHT_BASE) ||
                      (func_reg == tmrlm_pkg::FN_LIGHT_WORK);

    // clipped box of the circle
    logic signed [11:0] lo_x, hi_x, lo_y, hi_y, map_max;
    assign map_max = 12'(MAP_SIZE - 1);
    assign lo_x = $signed({px_reg[10], px_reg}) - $signed({4'b0000, rad_reg});
    assign hi_x = $signed({px_reg[10], px_reg}) + $signed({4'b0000, rad_reg});
    assign lo_y = $signed({py_reg[10], py_reg}) - $signed({4'b0000, rad_reg});
    assign hi_y = $signed({py_reg[10], py_reg}) + $signed({4'b0000, rad_reg});

    logic x_last, y_last;
    assign x_last = (x_reg == ex_reg[CW-1:0]);
    assign y_last = (y_reg == ey_reg[CW-1:0]);

    logic offx_wrap, offy_wrap, sxo_big, offy_big;
    assign offx_wrap = (32'(offx_reg) + 32'd1 == 32'(TILE_SIZE));
    assign offy_wrap = (32'(offy_reg) + 32'd1 == 32'(TILE_SIZE));
    assign sxo_big   = (32'(sxo_reg) >= 32'(TILE_SIZE));
    assign offy_big  = (32'(offy_reg) >= 32'(TILE_SIZE));

    // memories
    logic [TILE_AW-1:0]  tile_raddr, tile_waddr;
    logic                tile_we;
    tmrlm_pkg::tile_t    tile_rd;
    logic [TILE_AW+7:0]  idx_ext;
    logic [PIX_AW-1:0]   walk_addr, rd_addr, work_raddr;
    logic                base_we, work_we;
    logic [7:0]          base_wdata, work_wdata, base_rd, work_rd;

    assign idx_ext    = {{TILE_AW{1'b0}}, idx_reg};
    assign tile_waddr = idx_ext[TILE_AW-1:0];
    assign tile_we    = cmd.tile_wr && (idx_ext < (TILE_AW + 8)'(TILE_COUNT));
    assign tile_raddr = TILE_AW'(row_reg) * TILE_AW'(TILES_SIDE) + TILE_AW'(col_reg);
    assign walk_addr  = PIX_AW'(y_reg) * PIX_AW'(MAP_SIZE) + PIX_AW'(x_reg);

    logic rd_in_range;
    assign rd_in_range = !px_reg[10] && !py_reg[10] &&
                         (32'(px_reg[9:0]) < 32'(MAP_SIZE)) &&
                         (32'(py_reg[9:0]) < 32'(MAP_SIZE));
    assign rd_addr    = PIX_AW'(py_reg[9:0]) * PIX_AW'(MAP_SIZE) + PIX_AW'(px_reg[9:0]);
    assign work_raddr = (func_reg == tmrlm_pkg::FN_READ_WORK) ? rd_addr : walk_addr;

    tmrlm_ram #(.WIDTH($bits(tmrlm_pkg::tile_t)), .DEPTH(TILE_COUNT)) u_tile_ram (
        .clk   (clk),
        .we    (tile_we),
        .waddr (tile_waddr),
        .wdata (tile_in_reg),
        .raddr (tile_raddr),
        .rdata (tile_rd)
    );

    tmrlm_ram #(.WIDTH(8), .DEPTH(PIXELS)) u_base_ram (
        .clk   (clk),
        .we    (base_we),
        .waddr (walk_addr),
        .wdata (base_wdata),
        .raddr (walk_addr),
        .rdata (base_rd)
    );

    tmrlm_ram #(.WIDTH(8), .DEPTH(PIXELS)) u_work_ram (
        .clk   (clk),
        .we    (work_we),
        .waddr (walk_addr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rd)
    );

    // tile mask of the current pixel
    logic       unlit_x, unlit_y, damp, damp_unlit, lit;
    logic [7:0] shade;
    always_comb
    begin
        unlit_x = (tile_rd.edge_x != 8'd0) &&
                  (tile_rd.side[tmrlm_pkg::SIDE_X_BIT] ?
                   (32'(offx_reg) < 32'(tile_rd.edge_x)) :
                   (32'(offx_reg) > 32'(tile_rd.edge_x)));
        unlit_y = (tile_rd.edge_y != 8'd0) &&
                  (tile_rd.side[tmrlm_pkg::SIDE_Y_BIT] ?
                   (32'(offy_reg) < 32'(tile_rd.edge_y)) :
                   (32'(offy_reg) > 32'(tile_rd.edge_y)));
        damp       = (tile_rd.attr == tmrlm_pkg::ATTR_DAMP);
        damp_unlit = damp && (((tile_rd.edge_x == 8'd0) && (tile_rd.edge_y == 8'd0)) ||
                              unlit_x || unlit_y);
        shade = 8'd0;
        if (damp_unlit)
        begin
            shade = tile_rd.flags[tmrlm_pkg::FLAG_OUT_BIT] ? outl : amb;
        end
        else if (tile_rd.attr == tmrlm_pkg::ATTR_OUTDOOR)
        begin
            shade = outl;
        end
        if (tile_rd.attr2 == tmrlm_pkg::ATTR_OUTDOOR)
        begin
            shade = outl;
        end
        lit = !(damp_unlit || (tile_rd.attr == tmrlm_pkg::ATTR_OUTDOOR) ||
                (tile_rd.attr2 == tmrlm_pkg::ATTR_OUTDOOR));
    end

    // distance, falloff and light sum
    logic signed [11:0] dx_w, dy_w;
    logic signed [8:0]  dxs, dys;
    logic signed [17:0] sqx_w, sqy_w;
    logic [15:0]        r2;
    logic [16:0]        dist_sq;
    logic [24:0]        prod;
    logic [7:0]         falloff;
    logic [8:0]         sum;
    logic [7:0]         light_val, fill_val;

    assign dx_w  = $signed(12'(x_reg)) - $signed({px_reg[10], px_reg});
    assign dy_w  = $signed(12'(y_reg)) - $signed({py_reg[10], py_reg});
    assign dxs   = dx_w[8:0];
    assign dys   = dy_w[8:0];
    assign sqx_w = dxs * dxs;
    assign sqy_w = dys * dys;
    assign r2    = rad_reg * rad_reg;
    assign dist_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign prod  = dist_sq * int_reg;
    assign falloff   = int_reg - q_reg;
    assign sum       = {1'b0, falloff} + {1'b0, pix_reg};
    assign light_val = lit_reg ? (sum[8] ? 8'hFF : sum[7:0]) : shade_reg;
    assign fill_val  = lit ? amb : shade;

    assign base_we    = cmd.map_wr && ((func_reg == tmrlm_pkg::FN_FILL_BASE) ||
                                       (func_reg == tmrlm_pkg::FN_LIGHT_BASE));
    assign base_wdata = (func_reg == tmrlm_pkg::FN_FILL_BASE) ? fill_val : light_val;
    assign work_we    = cmd.map_wr && ((func_reg == tmrlm_pkg::FN_COPY) ||
                                       (func_reg == tmrlm_pkg::FN_LIGHT_WORK));
    assign work_wdata = (func_reg == tmrlm_pkg::FN_COPY) ? base_rd : light_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_reg   <= '0;
            outdoor_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == tmrlm_pkg::CFG_AMBIENT))
            begin
                ambient_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == tmrlm_pkg::CFG_OUTDOOR))
            begin
                outdoor_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= req.func;
            idx_reg     <= req.tile_index;
            tile_in_reg <= req.tile;
            px_reg      <= req.pos_x;
            py_reg      <= req.pos_y;
            rad_reg     <= req.radius;
            int_reg     <= req.intensity;
            level_reg   <= 8'd0;
        end
        if (cmd.bounds)
        begin
            if (is_light)
            begin
                sx_reg <= (lo_x < 0) ? 12'sd0 : lo_x;
                sy_reg <= (lo_y < 0) ? 12'sd0 : lo_y;
                ex_reg <= (hi_x > map_max) ? map_max : hi_x;
                ey_reg <= (hi_y > map_max) ? map_max : hi_y;
            end
            else
            begin
                sx_reg <= 12'sd0;
                sy_reg <= 12'sd0;
                ex_reg <= map_max;
                ey_reg <= map_max;
            end
        end
        if (cmd.start_walk)
        begin
            x_reg    <= sx_reg[CW-1:0];
            y_reg    <= sy_reg[CW-1:0];
            sxo_reg  <= sx_reg[CW-1:0];
            offy_reg <= sy_reg[CW-1:0];
            sxc_reg  <= '0;
            row_reg  <= '0;
        end
        if (cmd.reduce)
        begin
            if (sxo_big)
            begin
                sxo_reg <= sxo_reg - CW'(TILE_SIZE);
                sxc_reg <= sxc_reg + COL_W'(1);
            end
            if (offy_big)
            begin
                offy_reg <= offy_reg - CW'(TILE_SIZE);
                row_reg  <= row_reg + COL_W'(1);
            end
        end
        if (cmd.row_start)
        begin
            offx_reg <= sxo_reg;
            col_reg  <= sxc_reg;
        end
        if (cmd.advance)
        begin
            if (x_last)
            begin
                x_reg    <= sx_reg[CW-1:0];
                offx_reg <= sxo_reg;
                col_reg  <= sxc_reg;
                y_reg    <= y_reg + CW'(1);
                if (offy_wrap)
                begin
                    offy_reg <= '0;
                    row_reg  <= row_reg + COL_W'(1);
                end
                else
                begin
                    offy_reg <= offy_reg + CW'(1);
                end
            end
            else
            begin
                x_reg <= x_reg + CW'(1);
                if (offx_wrap)
                begin
                    offx_reg <= '0;
                    col_reg  <= col_reg + COL_W'(1);
                end
                else
                begin
                    offx_reg <= offx_reg + CW'(1);
                end
            end
        end
        if (cmd.square)
        begin
            sqx_reg <= sqx_w[15:0];
            sqy_reg <= sqy_w[15:0];
        end
        if (cmd.eval)
        begin
            lit_reg   <= lit;
            shade_reg <= shade;
            pix_reg   <= (func_reg == tmrlm_pkg::FN_LIGHT_BASE) ? base_rd : work_rd;
            rem_reg   <= prod;
            dsh_reg   <= {r2, 7'b0};
            q_reg     <= 8'd0;
        end
        // quotient stays below 256 because the distance never exceeds r^2
        if (cmd.div_step)
        begin
            if (rem_reg >= {2'b00, dsh_reg})
            begin
                rem_reg <= rem_reg - {2'b00, dsh_reg};
                q_reg   <= {q_reg[6:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[6:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.read_cap)
        begin
            level_reg <= rd_in_range ? work_rd : 8'd0;
        end
        if (cmd.out_load)
        begin
            out_level_reg <= level_reg;
            out_func_reg  <= func_reg;
        end
    end

    assign sts.func        = func_reg;
    assign sts.box_empty   = (sx_reg > ex_reg) || (sy_reg > ey_reg) ||
                             (is_light && ((rad_reg == 8'd0) || (int_reg == 8'd0)));
    assign sts.reduce_done = !sxo_big && !offy_big;
    assign sts.last_pixel  = x_last && y_last;
    assign sts.in_circle   = (dist_sq <= {1'b0, r2});
    assign sts.out_free    = !out_valid_reg || rsp_ready;

    assign rsp_valid     = out_valid_reg;
    assign rsp_level     = out_level_reg;
    assign rsp_func_echo = out_func_reg;

    a_wr_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.map_wr |-> (($signed(12'(x_reg)) <= ex_reg) && ($signed(12'(y_reg)) <= ey_reg)))
        else $error("map write outside the box");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (rem_reg < {2'b00, $past(dsh_reg)}))
        else $error("divider remainder out of range");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> rsp_valid)
        else $error("result not presented after load");

endmodule
